// ===== rtl/adsr_pkg.sv =====
// Shared types, constants and helper functions of the ADSR envelope generator.
package adsr_pkg;

  // Level storage width and the arithmetic width used for signed level math.
  localparam int unsigned LEVEL_WIDTH = 12;
  localparam int unsigned CALC_W      = LEVEL_WIDTH + 6;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_THRESHOLD = 3'd4;

  // Stage codes as they appear on the result.
  localparam logic [1:0] STAGE_CODE_ATTACK  = 2'd0;
  localparam logic [1:0] STAGE_CODE_DECAY   = 2'd1;
  localparam logic [1:0] STAGE_CODE_SUSTAIN = 2'd2;
  localparam logic [1:0] STAGE_CODE_RELEASE = 2'd3;

  // Envelope stage, one-hot.
  typedef enum logic [3:0] {
    STG_ATTACK  = 4'b0001,
    STG_DECAY   = 4'b0010,
    STG_SUSTAIN = 4'b0100,
    STG_RELEASE = 4'b1000
  } stage_e;

  typedef struct packed {
    logic kind;
    logic key_down;
  } in_item_t;

  typedef struct packed {
    logic [11:0] env_value;
    logic [1:0]  env_stage;
    logic        held;
  } out_item_t;

  typedef struct packed {
    logic [4:0] attack_step;
    logic [4:0] first_decay_step;
    logic [4:0] second_decay_step;
    logic [3:0] release_step;
    logic [3:0] sustain_threshold;
  } cfg_t;

  typedef struct packed {
    logic                   held;
    stage_e                 stage;
    logic [LEVEL_WIDTH-1:0] level;
  } env_state_t;

  function automatic logic [1:0] stage_code(stage_e stg);
    logic [1:0] code;
    case (stg)
      STG_ATTACK:  code = STAGE_CODE_ATTACK;
      STG_DECAY:   code = STAGE_CODE_DECAY;
      STG_SUSTAIN: code = STAGE_CODE_SUSTAIN;
      default:     code = STAGE_CODE_RELEASE;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/adsr_envelope_generator.sv =====
// Top level of the four-stage ADSR envelope generator of one operator.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_i  (in_item_t: kind, key_down)
// out       output     out_valid_o / out_ready_i out_o (out_item_t: level, stage, held)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// For every accepted transaction the next envelope state is computed
// from the state registers in a single combinational pass and lands in the state
// registers and the result register at the same edge. Sustained rate is one
// transaction per cycle while the result side keeps taking results.
// The result register is the only buffer: while a result waits unaccepted, the
// input side is held off until that result is taken in the same cycle.
// Reset is asynchronous and active low; it clears the configuration, drops the
// held flag, puts the stage in release and the level at zero.
module adsr_envelope_generator import adsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_i,
  // Result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_o,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  env_state_t st_q, st_d;
  out_item_t  out_q;
  logic       out_valid_q;
  logic       in_fire;

  // Configuration writes are always taken; the register file has no back pressure.
  assign cfg_ready_o = 1'b1;

  adsr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  adsr_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (in_i),
    .st_o   (st_d)
  );

  // A new transaction enters when the result register is empty or is being
  // emptied in this same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.held   <= 1'b0;
      st_q.stage  <= STG_RELEASE;
      st_q.level  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only looked at while out_valid_o is high.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.env_value <= st_d.level;
      out_q.env_stage <= stage_code(st_d.stage);
      out_q.held      <= st_d.held;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/adsr_cfg_regs.sv =====
// Configuration register file of the ADSR envelope generator.
module adsr_cfg_regs import adsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATTACK_STEP:       cfg_q.attack_step       <= cfg_data_i[4:0];
        CFG_FIRST_DECAY_STEP:  cfg_q.first_decay_step  <= cfg_data_i[4:0];
        CFG_SECOND_DECAY_STEP: cfg_q.second_decay_step <= cfg_data_i[4:0];
        CFG_RELEASE_STEP:      cfg_q.release_step      <= cfg_data_i[3:0];
        CFG_SUSTAIN_THRESHOLD: cfg_q.sustain_threshold <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/adsr_step.sv =====
// Next-state logic of the envelope for one tick or key event.
module adsr_step import adsr_pkg::*; (
  input  cfg_t       cfg_i,
  input  env_state_t st_i,
  input  in_item_t   item_i,
  output env_state_t st_o
);

  logic signed [CALC_W-1:0] lvl_s;
  logic signed [CALC_W-1:0] max_s;
  logic signed [CALC_W-1:0] floor_raw;
  logic signed [CALC_W-1:0] floor_s;
  logic signed [CALC_W-1:0] atk_sum;
  logic signed [CALC_W-1:0] dec_diff;
  logic signed [CALC_W-1:0] sus_diff;
  logic signed [CALC_W-1:0] rel_held_diff;
  logic signed [CALC_W-1:0] rel_free_diff;

  assign lvl_s     = CALC_W'(st_i.level);
  assign max_s     = CALC_W'(LEVEL_MAX);
  assign floor_raw = CALC_W'({cfg_i.sustain_threshold, 7'b0});
  assign floor_s   = (floor_raw > max_s) ? max_s : floor_raw;

  assign atk_sum       = lvl_s + CALC_W'({cfg_i.attack_step, 2'b0});
  assign dec_diff      = lvl_s - CALC_W'(cfg_i.first_decay_step);
  assign sus_diff      = lvl_s - CALC_W'(cfg_i.second_decay_step);
  assign rel_held_diff = lvl_s - CALC_W'({cfg_i.release_step, 1'b0});
  assign rel_free_diff = lvl_s - CALC_W'({cfg_i.release_step, 2'b0});

  always_comb begin
    st_o = st_i;
    if (item_i.kind) begin
      if (item_i.key_down) begin
        st_o.held  = 1'b1;
        st_o.stage = STG_ATTACK;
        st_o.level = '0;
      end else begin
        st_o.held = 1'b0;
      end
    end else if (!st_i.held) begin
      // Key released: fall at four times the release step down to zero.
      if (rel_free_diff < 0) begin
        st_o.level = '0;
      end else begin
        st_o.level = rel_free_diff[LEVEL_WIDTH-1:0];
      end
    end else begin
      case (st_i.stage)
        STG_ATTACK: begin
          if (atk_sum >= max_s) begin
            st_o.level = LEVEL_MAX;
            st_o.stage = STG_DECAY;
          end else begin
            st_o.level = atk_sum[LEVEL_WIDTH-1:0];
          end
        end
        STG_DECAY: begin
          if (dec_diff <= floor_s) begin
            st_o.level = floor_s[LEVEL_WIDTH-1:0];
            st_o.stage = STG_SUSTAIN;
          end else begin
            st_o.level = dec_diff[LEVEL_WIDTH-1:0];
          end
        end
        STG_SUSTAIN: begin
          // A level already at or below the floor is left alone.
          if (lvl_s > floor_s) begin
            if (sus_diff < floor_s) begin
              st_o.level = floor_s[LEVEL_WIDTH-1:0];
            end else begin
              st_o.level = sus_diff[LEVEL_WIDTH-1:0];
            end
          end
        end
        default: begin
          if (rel_held_diff < 0) begin
            st_o.level = '0;
          end else begin
            st_o.level = rel_held_diff[LEVEL_WIDTH-1:0];
          end
        end
      endcase
    end
  end

endmodule
